// ----- rtl/rsd_pkg.sv -----
// package for the row standard deviation unit: widths, queue entry and link types
`timescale 1ns / 1ps

package rsd_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int DEV_W        = 16;
    localparam int SUM_W        = 41;
    localparam int COUNT_W      = 11;
    localparam int SQ_W         = 31;
    localparam int ROOT_IN_W    = 32;
    localparam int SQRT_STEPS   = ROOT_IN_W / 2;
    localparam int MAX_SAMPLES_DEFAULT = 1024;
    localparam int QUEUE_DEPTH  = 4;
    localparam int Q_PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int Q_FREE_W     = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COUNT_W-1:0] count;
        logic               overflow;
    } t_row_sum;

    typedef struct packed {
        logic     valid;
        t_row_sum data;
    } t_q_push;

    typedef struct packed {
        logic     valid;
        t_row_sum data;
    } t_q_head;

endpackage

// ----- rtl/rsd_if.sv -----
// valid/ready channel interfaces for the sample input and the deviation result
`timescale 1ns / 1ps

interface rsd_in_if;
    import rsd_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic signed [SAMPLE_W-1:0] row_mean;
    logic                       last;

    modport source (output valid, output sample, output row_mean, output last, input ready);
    modport sink   (input valid, input sample, input row_mean, input last, output ready);
endinterface

interface rsd_out_if;
    import rsd_pkg::*;

    logic             valid;
    logic             ready;
    logic [DEV_W-1:0] deviation;
    logic             overflow;

    modport source (output valid, output deviation, output overflow, input ready);
    modport sink   (input valid, input deviation, input overflow, output ready);
endinterface

// ----- rtl/rsd_front.sv -----
// front end: accepts samples, squares the saturated difference and accumulates per row
`timescale 1ns / 1ps

module rsd_front #(
    parameter int MAX_SAMPLES = rsd_pkg::MAX_SAMPLES_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rsd_in_if.sink                        i_in,
    input  logic [rsd_pkg::Q_FREE_W-1:0]  i_free,
    output rsd_pkg::t_q_push              o_push
);
    import rsd_pkg::*;

    logic                r_sq_valid;
    logic                r_sq_add;
    logic                r_sq_last;
    logic [SQ_W-1:0]     r_sq;
    logic [COUNT_W-1:0]  r_sq_count;
    logic                r_sq_ovf;
    logic [SUM_W-1:0]    r_sum;
    logic [COUNT_W-1:0]  r_count;
    logic                r_ovf;

    logic [COUNT_W-1:0]  n_count;
    logic                n_ovf;
    logic [SUM_W-1:0]    n_sum;

    logic                pending;
    logic                accept;
    logic                room;
    logic signed [SAMPLE_W:0]   diff;
    logic        [SAMPLE_W-1:0] sat;
    logic        [SAMPLE_W-1:0] mag;
    logic        [2*SAMPLE_W-1:0] sq;

    // a row end still in the square stage holds a queue slot it has not taken yet
    assign pending = r_sq_valid && r_sq_last;
    assign room    = i_free > Q_FREE_W'(pending);
    assign i_in.ready = room;
    assign accept  = i_in.valid && room;

    assign diff = {i_in.sample[SAMPLE_W-1], i_in.sample}
                - {i_in.row_mean[SAMPLE_W-1], i_in.row_mean};

    always_comb begin
        if (diff[SAMPLE_W] != diff[SAMPLE_W-1]) begin
            sat = diff[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            sat = diff[SAMPLE_W-1:0];
        end
        mag = sat[SAMPLE_W-1] ? (~sat + SAMPLE_W'(1)) : sat;
        sq  = mag * mag;
    end

    always_comb begin
        if (r_count < COUNT_W'(MAX_SAMPLES)) begin
            n_count = r_count + COUNT_W'(1);
            n_ovf   = r_ovf;
        end else begin
            n_count = r_count;
            n_ovf   = 1'b1;
        end
        n_sum = r_sq_add ? (r_sum + SUM_W'(r_sq)) : r_sum;
    end

    assign o_push.valid         = pending;
    assign o_push.data.sum      = n_sum;
    assign o_push.data.count    = r_sq_count;
    assign o_push.data.overflow = r_sq_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid <= 1'b0;
            r_sum      <= '0;
            r_count    <= '0;
            r_ovf      <= 1'b0;
        end else begin
            r_sq_valid <= accept;
            if (accept) begin
                r_count <= i_in.last ? '0 : n_count;
                r_ovf   <= i_in.last ? 1'b0 : n_ovf;
            end
            if (r_sq_valid) begin
                r_sum <= r_sq_last ? '0 : n_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sq       <= sq[SQ_W-1:0];
            r_sq_add   <= r_count < COUNT_W'(MAX_SAMPLES);
            r_sq_last  <= i_in.last;
            r_sq_count <= n_count;
            r_sq_ovf   <= n_ovf;
        end
    end

endmodule

// ----- rtl/rsd_queue.sv -----
// short queue of finished row sums between front and back end
`timescale 1ns / 1ps

module rsd_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rsd_pkg::t_q_push              i_push,
    output logic [rsd_pkg::Q_FREE_W-1:0]  o_free,
    output rsd_pkg::t_q_head              o_head,
    input  logic                          i_pop
);
    import rsd_pkg::*;

    t_row_sum            mem [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]  r_wr;
    logic [Q_PTR_W-1:0]  r_rd;
    logic [Q_FREE_W-1:0] r_count;

    logic do_pop;

    assign do_pop       = i_pop && (r_count != '0);
    assign o_free       = Q_FREE_W'(QUEUE_DEPTH) - r_count;
    assign o_head.valid = r_count != '0;
    assign o_head.data  = mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr <= r_wr + Q_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + Q_PTR_W'(1);
            end
            r_count <= r_count + Q_FREE_W'(i_push.valid) - Q_FREE_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            mem[r_wr] <= i_push.data;
        end
    end

endmodule

// ----- rtl/rsd_back.sv -----
// back end: bit-serial divide of the row sum by its count, then bit-pair square root
`timescale 1ns / 1ps

module rsd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rsd_pkg::t_q_head  i_head,
    output logic              o_pop,
    rsd_out_if.source         o_out
);
    import rsd_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQRT,
        ST_OUT
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [SUM_W-1:0]    r_quo;
    logic [COUNT_W-1:0]  r_rem;
    logic [COUNT_W-1:0]  r_div;
    logic                r_ovf;
    logic [ROOT_IN_W-1:0] r_x;
    logic [ROOT_IN_W-1:0] r_res;
    logic [ROOT_IN_W-1:0] r_bit;
    logic                r_out_valid;
    logic [DEV_W-1:0]    r_dev;

    logic [COUNT_W:0]     rem_sh;
    logic                 q_bit;
    logic [COUNT_W-1:0]   n_rem;
    logic [SUM_W-1:0]     n_quo;
    logic [ROOT_IN_W-1:0] quo_sat;
    logic [ROOT_IN_W-1:0] trial;
    logic                 take;
    logic [ROOT_IN_W-1:0] n_x;
    logic [ROOT_IN_W-1:0] n_res;

    // restoring divide, one quotient bit a cycle
    always_comb begin
        rem_sh = {r_rem, r_quo[SUM_W-1]};
        q_bit  = rem_sh >= {1'b0, r_div};
        n_rem  = q_bit ? COUNT_W'(rem_sh - {1'b0, r_div}) : rem_sh[COUNT_W-1:0];
        n_quo  = {r_quo[SUM_W-2:0], q_bit};
        if (r_div == '0) begin
            quo_sat = '0;
        end else if (n_quo[SUM_W-1:ROOT_IN_W] != '0) begin
            quo_sat = '1;
        end else begin
            quo_sat = n_quo[ROOT_IN_W-1:0];
        end
    end

    always_comb begin
        trial = r_res + r_bit;
        take  = r_x >= trial;
        n_x   = take ? (r_x - trial) : r_x;
        n_res = take ? ((r_res >> 1) + r_bit) : (r_res >> 1);
    end

    assign o_pop           = (r_state == ST_IDLE) && i_head.valid;
    assign o_out.valid     = r_out_valid;
    assign o_out.deviation = r_dev;
    assign o_out.overflow  = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_head.valid) begin
                        r_quo   <= i_head.data.sum;
                        r_div   <= i_head.data.count;
                        r_ovf   <= i_head.data.overflow;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_quo <= n_quo;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(SUM_W - 1)) begin
                        r_x     <= quo_sat;
                        r_res   <= '0;
                        r_bit   <= ROOT_IN_W'(1) << (ROOT_IN_W - 2);
                        r_cnt   <= '0;
                        r_state <= ST_SQRT;
                    end
                end
                ST_SQRT: begin
                    r_x   <= n_x;
                    r_res <= n_res;
                    r_bit <= r_bit >> 2;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                        r_dev       <= n_res[DEV_W-1:0];
                        r_out_valid <= 1'b1;
                        r_state     <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (o_out.ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/row_std_deviation_unit.sv -----
// top level of the row standard deviation unit: front end, row queue and divide/root back end
//
//  channel  dir  beat contents                         accepted when
//  i_in     in   sample, row_mean, last                i_in.valid && i_in.ready
//  o_out    out  deviation (unsigned Q8.8), overflow   o_out.valid && o_out.ready
//
// the front end takes one sample beat every cycle while the row queue has a free slot
// a row end's result passes through 1 square stage, the row queue, 41 divide steps
// and 16 root steps in the shared back end
// rows that end while the back end is busy wait in the four-entry queue; input stalls only when it fills
// a stalled result holds the back end, never the front end directly; reset is synchronous
`timescale 1ns / 1ps

module row_std_deviation_unit #(
    parameter int MAX_SAMPLES = rsd_pkg::MAX_SAMPLES_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rsd_in_if.sink    i_in,
    rsd_out_if.source o_out
);
    import rsd_pkg::*;

    t_q_push             push;
    t_q_head             head;
    logic [Q_FREE_W-1:0] free;
    logic                pop;

    rsd_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_free  (free),
        .o_push  (push)
    );

    rsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_free  (free),
        .o_head  (head),
        .i_pop   (pop)
    );

    rsd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
